>>> rtl/core/mnd_pkg.sv
// ----------------------------------------------------------------------------
// mnd_pkg: shared types, constants and lookup functions for the note decoder
// Holds the transaction structs, the register indexes, the pipeline stage
// records and the pitch tables used by melody_note_decoder_core.
// ----------------------------------------------------------------------------
`default_nettype none

package mnd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_SHIFT        = 2'd0;
  localparam logic [1:0] CFG_OCTAVE_SHIFT     = 2'd1;
  localparam logic [1:0] CFG_WHOLE_NOTE_MS    = 2'd2;
  localparam logic [1:0] CFG_SUSTAIN_FRACTION = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [3:0]        KEY_SHIFT_RST        = 4'd0;
  localparam logic signed [2:0] OCTAVE_SHIFT_RST     = 3'sd0;
  localparam logic [15:0]       WHOLE_NOTE_MS_RST    = 16'd1600;
  localparam logic [8:0]        SUSTAIN_FRACTION_RST = 9'd205;

  // saturation and wrap limits
  localparam logic [3:0]  KEY_SHIFT_MAX  = 4'd11;
  localparam logic [15:0] WHOLE_NOTE_MAX = 16'd40000;
  localparam logic [8:0]  SUSTAIN_MAX    = 9'd256;

  // digit limits of the decimal codes
  localparam logic [3:0] NOTE_MAX   = 4'd7;
  localparam logic [3:0] RANGE_MAX  = 4'd3;
  localparam logic [1:0] FLAG_MAX   = 2'd1;
  localparam logic [3:0] EXPO_MAX   = 4'd6;
  localparam logic [3:0] EFFECT_MAX = 4'd2;
  localparam logic [3:0] NOTE_REST  = 4'd0;

  // effect codes
  localparam logic [1:0] EFFECT_NORMAL   = 2'd0;
  localparam logic [1:0] EFFECT_LEGATO   = 2'd1;
  localparam logic [1:0] EFFECT_STACCATO = 2'd2;

  // octave digit codes
  localparam logic [1:0] RANGE_LOW  = 2'd1;
  localparam logic [1:0] RANGE_HIGH = 2'd3;

  // semitones in an octave
  localparam logic [4:0] SEMITONES = 5'd12;

  typedef struct packed {
    logic [7:0] tone_code;
    logic [7:0] length_code;
  } mnd_in_t;

  typedef struct packed {
    logic [12:0] frequency_hz;
    logic [15:0] sound_ms;
    logic [15:0] silence_ms;
    logic        bad_code;
  } mnd_out_t;

  // three decimal digits of an 8-bit code
  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_digits_t;

  // stage 1: split digits and range check
  typedef struct packed {
    logic [3:0] note;
    logic [1:0] range;
    logic       sharp;
    logic [2:0] expo;
    logic [1:0] effect;
    logic       dotted;
    logic       bad;
  } s1_t;

  // stage 2: base pitch and note length
  typedef struct packed {
    logic        rest;
    logic [1:0]  range;
    logic [8:0]  base;
    logic        wrap;
    logic [15:0] span_ms;
    logic [1:0]  effect;
    logic        bad;
  } s2_t;

  // stage 3: shifted pitch and scaled length
  typedef struct packed {
    logic        rest;
    logic [12:0] freq;
    logic [15:0] span_ms;
    logic [15:0] scaled;
    logic [1:0]  effect;
    logic        bad;
  } s3_t;

  // decimal split by reciprocal multiply: x/10 == (x*205)>>11 for x < 1029
  function automatic dec_digits_t split_digits(input logic [7:0] x);
    logic [15:0] p1;
    logic [4:0]  q1;
    logic [12:0] p2;
    logic [1:0]  q2;
    dec_digits_t d;
    p1 = 16'(x) * 16'd205;
    q1 = p1[15:11];
    p2 = 13'(q1) * 13'd205;
    q2 = p2[12:11];
    d.ones = 4'(x - 8'(8'(q1) * 8'd10));
    d.tens = 4'(q1 - 5'(5'(q2) * 5'd10));
    d.hund = q2;
    return d;
  endfunction

  // semitone position of a scale degree (degree 0 is the first note)
  function automatic logic [3:0] degree_pos(input logic [2:0] deg);
    logic [3:0] pos;
    case (deg)
      3'd0: pos = 4'd0;
      3'd1: pos = 4'd2;
      3'd2: pos = 4'd4;
      3'd3: pos = 4'd5;
      3'd4: pos = 4'd7;
      3'd5: pos = 4'd9;
      3'd6: pos = 4'd11;
      default: pos = 4'd0;
    endcase
    return pos;
  endfunction

  // middle octave frequencies in Hz
  function automatic logic [8:0] base_freq(input logic [3:0] idx);
    logic [8:0] f;
    case (idx)
      4'd0:  f = 9'd262;
      4'd1:  f = 9'd277;
      4'd2:  f = 9'd294;
      4'd3:  f = 9'd311;
      4'd4:  f = 9'd330;
      4'd5:  f = 9'd349;
      4'd6:  f = 9'd369;
      4'd7:  f = 9'd392;
      4'd8:  f = 9'd415;
      4'd9:  f = 9'd440;
      4'd10: f = 9'd466;
      4'd11: f = 9'd494;
      default: f = 9'd0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/melody_note_decoder_core.sv
// ----------------------------------------------------------------------------
// melody_note_decoder_core: buzzer melody note decoder
// Turns a decimal note code and a decimal length code into a tone frequency,
// a sounding time and a silent time, after key and octave transposition.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one note transaction (tone_code and
//   length_code); out_valid/out_ready/out_data carry its result (frequency,
//   sound time, silence time, bad code flag). Every input gives one result.
//   cfg_we/cfg_index/cfg_wdata write the key shift, octave shift, whole note
//   time and sustain fraction; write them only while no note is in flight.
//   Out-of-range register values are clamped when written; a key shift above 11 wraps down by 12.
// Pipeline: four registered stages from input acceptance to result valid
//   (digit split, pitch lookup and length shift, octave shifts and the 16x9
//   sustain multiply, then the final select into the output register).
// Throughput: one transaction per cycle while out_ready is high; each stage
//   holds one note and moves when it is empty or the stage after it moves.
// Reset: the pipeline empties and the registers return to key shift 0,
//   octave shift 0, whole note 1600 ms and sustain 205/256.
// Stall: when out_ready is low, the result holds and the stages fill up;
//   in_ready drops once all four are occupied. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module melody_note_decoder_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire mnd_pkg::mnd_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output mnd_pkg::mnd_out_t                     out_data,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [mnd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers, stored already clamped (key shift wrapped)
  logic [3:0]        key_shift_r;
  logic signed [2:0] octave_shift_r;
  logic [15:0]       whole_note_r;
  logic [8:0]        sustain_r;

  // pipeline state
  logic             v1_r, v2_r, v3_r, out_valid_r;
  mnd_pkg::s1_t     s1_r, s1_nxt;
  mnd_pkg::s2_t     s2_r, s2_nxt;
  mnd_pkg::s3_t     s3_r, s3_nxt;
  mnd_pkg::mnd_out_t out_r, out_nxt;
  logic             adv1, adv2, adv3, adv4;

  // configuration writes with clamping and key shift wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_shift_r    <= mnd_pkg::KEY_SHIFT_RST;
      octave_shift_r <= mnd_pkg::OCTAVE_SHIFT_RST;
      whole_note_r   <= mnd_pkg::WHOLE_NOTE_MS_RST;
      sustain_r      <= mnd_pkg::SUSTAIN_FRACTION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mnd_pkg::CFG_KEY_SHIFT: begin
          if (cfg_wdata[3:0] > mnd_pkg::KEY_SHIFT_MAX)
            key_shift_r <= 4'(cfg_wdata[3:0] - 4'(mnd_pkg::SEMITONES));
          else
            key_shift_r <= cfg_wdata[3:0];
        end
        mnd_pkg::CFG_OCTAVE_SHIFT: begin
          case (cfg_wdata[2:0])
            3'b100, 3'b101: octave_shift_r <= -3'sd2;
            3'b011:         octave_shift_r <= 3'sd2;
            default:        octave_shift_r <= signed'(cfg_wdata[2:0]);
          endcase
        end
        mnd_pkg::CFG_WHOLE_NOTE_MS: begin
          if (cfg_wdata[15:0] > mnd_pkg::WHOLE_NOTE_MAX)
            whole_note_r <= mnd_pkg::WHOLE_NOTE_MAX;
          else
            whole_note_r <= cfg_wdata[15:0];
        end
        mnd_pkg::CFG_SUSTAIN_FRACTION: begin
          if (cfg_wdata[8:0] > mnd_pkg::SUSTAIN_MAX)
            sustain_r <= mnd_pkg::SUSTAIN_MAX;
          else
            sustain_r <= cfg_wdata[8:0];
        end
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when it is empty or the next one moves
  assign adv4     = !out_valid_r || out_ready;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // stage 1: decimal split and digit checks
  always_comb begin
    mnd_pkg::dec_digits_t td;
    mnd_pkg::dec_digits_t ld;
    logic bad;
    td  = mnd_pkg::split_digits(in_data.tone_code);
    ld  = mnd_pkg::split_digits(in_data.length_code);
    bad = (td.ones > mnd_pkg::NOTE_MAX) || (td.tens > mnd_pkg::RANGE_MAX) ||
          (td.hund > mnd_pkg::FLAG_MAX) ||
          ((td.ones == mnd_pkg::NOTE_MAX) && (td.hund == mnd_pkg::FLAG_MAX)) ||
          (ld.ones > mnd_pkg::EXPO_MAX) || (ld.tens > mnd_pkg::EFFECT_MAX) ||
          (ld.hund > mnd_pkg::FLAG_MAX);
    s1_nxt.note   = td.ones;
    s1_nxt.range  = td.tens[1:0];
    s1_nxt.sharp  = td.hund[0];
    s1_nxt.expo   = ld.ones[2:0];
    s1_nxt.effect = ld.tens[1:0];
    s1_nxt.dotted = ld.hund[0];
    s1_nxt.bad    = bad;
  end

  // stage 2: transposed table lookup and note length
  always_comb begin
    logic [4:0]  j;
    logic [3:0]  idx;
    logic [15:0] len;
    j = 5'(mnd_pkg::degree_pos(3'(s1_r.note - 4'd1))) + 5'(s1_r.sharp) + 5'(key_shift_r);
    if (j >= mnd_pkg::SEMITONES) begin
      idx = 4'(j - mnd_pkg::SEMITONES);
      s2_nxt.wrap = 1'b1;
    end else begin
      idx = j[3:0];
      s2_nxt.wrap = 1'b0;
    end
    len = whole_note_r >> s1_r.expo;
    if (s1_r.dotted)
      len = 16'(len + (len >> 1));
    s2_nxt.rest    = (s1_r.note == mnd_pkg::NOTE_REST);
    s2_nxt.range   = s1_r.range;
    s2_nxt.base    = mnd_pkg::base_freq(idx);
    s2_nxt.span_ms = len;
    s2_nxt.effect  = s1_r.effect;
    s2_nxt.bad     = s1_r.bad;
  end

  // stage 3: octave shifts and sustain multiply
  always_comb begin
    logic [9:0]  f1;
    logic [11:0] f2;
    logic [12:0] f3;
    logic [24:0] prod;
    f1 = s2_r.wrap ? {s2_r.base, 1'b0} : {1'b0, s2_r.base};
    case (octave_shift_r)
      -3'sd2:  f2 = 12'(f1 >> 2);
      -3'sd1:  f2 = 12'(f1 >> 1);
      3'sd1:   f2 = {1'b0, f1, 1'b0};
      3'sd2:   f2 = {f1, 2'b00};
      default: f2 = 12'(f1);
    endcase
    case (s2_r.range)
      mnd_pkg::RANGE_LOW:  f3 = 13'(f2 >> 1);
      mnd_pkg::RANGE_HIGH: f3 = {f2, 1'b0};
      default:             f3 = 13'(f2);
    endcase
    prod = 25'(s2_r.span_ms) * 25'(sustain_r);
    s3_nxt.rest    = s2_r.rest;
    s3_nxt.freq    = f3;
    s3_nxt.span_ms = s2_r.span_ms;
    s3_nxt.scaled  = prod[23:8];
    s3_nxt.effect  = s2_r.effect;
    s3_nxt.bad     = s2_r.bad;
  end

  // stage 4: effect select, rest and bad code handling
  always_comb begin
    logic [15:0] sound;
    case (s3_r.effect)
      mnd_pkg::EFFECT_NORMAL:   sound = s3_r.scaled;
      mnd_pkg::EFFECT_LEGATO:   sound = s3_r.span_ms;
      mnd_pkg::EFFECT_STACCATO: sound = s3_r.span_ms >> 1;
      default:                  sound = s3_r.span_ms;
    endcase
    if (s3_r.rest)
      sound = 16'd0;
    if (s3_r.bad) begin
      out_nxt.frequency_hz = 13'd0;
      out_nxt.sound_ms     = 16'd0;
      out_nxt.silence_ms   = 16'd0;
      out_nxt.bad_code     = 1'b1;
    end else begin
      out_nxt.frequency_hz = s3_r.rest ? 13'd0 : s3_r.freq;
      out_nxt.sound_ms     = sound;
      out_nxt.silence_ms   = 16'(s3_r.span_ms - sound);
      out_nxt.bad_code     = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_valid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) v3_r        <= v2_r;
      if (adv4) out_valid_r <= v3_r;
    end
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (adv1) s1_r  <= s1_nxt;
    if (adv2) s2_r  <= s2_nxt;
    if (adv3) s3_r  <= s3_nxt;
    if (adv4) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // a bad code result carries all-zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_code |->
      (out_data.frequency_hz == 13'd0) && (out_data.sound_ms == 16'd0) &&
      (out_data.silence_ms == 16'd0))
    else $error("bad code result with nonzero fields");

  // frequency stays within the highest transposed note
  a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frequency_hz <= 13'd7904))
    else $error("frequency out of range");

  // an accepted transaction always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transaction lost at stage 1");

  // a stalled stage 3 keeps its note
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !adv3 |=> v3_r && $stable(s3_r))
    else $error("stage 3 note lost during stall");

  // input back-pressure only when every stage is occupied
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

>>> bench/melody_note_decoder_checker.sv
// ----------------------------------------------------------------------------
// melody_note_decoder_checker: result predictor and comparator
// Watches the note, result and register ports of melody_note_decoder_core,
// keeps its own copy of the four registers, predicts the frequency, sound time
// and silence time of every accepted note and checks each result in order.
// ----------------------------------------------------------------------------
module melody_note_decoder_checker
  import mnd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  mnd_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  mnd_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           notes_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    mnd_in_t  note;
    mnd_out_t want;
  } pending_note_t;

  // middle octave pitches and semitone offsets of the scale degrees
  int unsigned middle_hz [12] = '{262, 277, 294, 311, 330, 349, 369, 392, 415, 440, 466, 494};
  int unsigned degree_step [7] = '{0, 2, 4, 5, 7, 9, 11};

  // shadow copy of the register file, stored at register width
  logic [3:0]        key_reg;
  logic signed [2:0] octave_reg;
  logic [15:0]       whole_reg;
  logic [8:0]        sustain_reg;

  pending_note_t pending_q [$];

  initial begin
    fail_count      = 0;
    notes_in_flight = 0;
  end

  // frequency and durations of one note under the current register values
  function automatic mnd_out_t decode_note(input mnd_in_t item);
    int unsigned tone, len, note, octave, sharp, expo, effect, dotted;
    int unsigned key, slot, pitch, whole, span, sustain, sound;
    int          oct_shift;
    mnd_out_t    r;
    tone   = item.tone_code;
    len    = item.length_code;
    note   = tone % 10;
    octave = (tone / 10) % 10;
    sharp  = tone / 100;
    expo   = len % 10;
    effect = (len / 10) % 10;
    dotted = len / 100;
    r      = '0;
    // any digit out of range, or a sharp seventh, flags the code
    if (note > 7 || octave > 3 || sharp > 1 || (note == 7 && sharp == 1) ||
        expo > 6 || effect > 2 || dotted > 1) begin
      r.bad_code = 1'b1;
      return r;
    end
    // pitch: key shift wraps into the next octave, then both octave shifts
    pitch = 0;
    if (note != 0) begin
      key = key_reg;
      if (key > 11) key -= 12;
      slot = degree_step[note - 1] + sharp + key;
      pitch = (slot > 11) ? 2 * middle_hz[slot - 12] : middle_hz[slot];
      oct_shift = octave_reg;
      if (oct_shift < -2) oct_shift = -2;
      if (oct_shift > 2) oct_shift = 2;
      if (oct_shift < 0) pitch = pitch >> (-oct_shift);
      else pitch = pitch << oct_shift;
      if (octave == RANGE_LOW) pitch = pitch >> 1;
      if (octave == RANGE_HIGH) pitch = pitch << 1;
    end
    // durations: saturated whole note, power-of-two divide, optional dot
    whole = whole_reg;
    if (whole > WHOLE_NOTE_MAX) whole = WHOLE_NOTE_MAX;
    span = whole >> expo;
    if (dotted == 1) span += span / 2;
    sustain = sustain_reg;
    if (sustain > SUSTAIN_MAX) sustain = SUSTAIN_MAX;
    case (effect)
      EFFECT_NORMAL: sound = (span * sustain) >> 8;
      EFFECT_LEGATO: sound = span;
      default:       sound = span / 2;
    endcase
    if (note == 0) sound = 0;
    r.frequency_hz = 13'(pitch);
    r.sound_ms     = 16'(sound);
    r.silence_ms   = 16'(span - sound);
    return r;
  endfunction

  // register writes, result checks and note predictions at each edge
  always @(posedge clk) begin
    pending_note_t head;
    if (!rst_n) begin
      key_reg     <= KEY_SHIFT_RST;
      octave_reg  <= OCTAVE_SHIFT_RST;
      whole_reg   <= WHOLE_NOTE_MS_RST;
      sustain_reg <= SUSTAIN_FRACTION_RST;
      pending_q.delete();
      notes_in_flight <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_SHIFT:        key_reg     <= cfg_wdata[3:0];
          CFG_OCTAVE_SHIFT:     octave_reg  <= cfg_wdata[2:0];
          CFG_WHOLE_NOTE_MS:    whole_reg   <= cfg_wdata[15:0];
          CFG_SUSTAIN_FRACTION: sustain_reg <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result freq=%0d sound=%0d silence=%0d bad=%0b",
                     $time, out_data.frequency_hz, out_data.sound_ms,
                     out_data.silence_ms, out_data.bad_code);
          fail_count++;
        end else begin
          head = pending_q.pop_front();
          if (out_data !== head.want) begin
            if (fail_count < 10)
              $display("%0t: tone %0d length %0d: expected freq=%0d sound=%0d silence=%0d bad=%0b, got freq=%0d sound=%0d silence=%0d bad=%0b",
                       $time, head.note.tone_code, head.note.length_code,
                       head.want.frequency_hz, head.want.sound_ms,
                       head.want.silence_ms, head.want.bad_code,
                       out_data.frequency_hz, out_data.sound_ms,
                       out_data.silence_ms, out_data.bad_code);
            fail_count++;
          end
        end
      end
      // note transaction
      if (in_valid && in_ready) begin
        head.note = in_data;
        head.want = decode_note(in_data);
        pending_q.push_back(head);
      end
      notes_in_flight <= pending_q.size();
    end
  end

endmodule

>>> bench/melody_note_decoder_core_test.sv
// ----------------------------------------------------------------------------
// melody_note_decoder_core_test: testbench top for the note decoder
// Drives directed and random note codes through several register settings,
// including out-of-range register values, with random idling on both sides
// and long result stalls; the checker module predicts and compares results.
// ----------------------------------------------------------------------------
module melody_note_decoder_core_test;
  import mnd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned CHOKE_CYCLES = 64;
  localparam int unsigned PHASE_NOTES  = 246;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  mnd_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  mnd_out_t              out_data;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned failures;
  int unsigned notes_in_flight;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned stall_cycles = 0;

  // rests, every degree and octave, sharps, effects and bad digits
  mnd_in_t opening_notes [26] = '{
    {8'd0,   8'd0},   {8'd20,  8'd1},   {8'd100, 8'd12},  {8'd30,  8'd106},
    {8'd1,   8'd0},   {8'd12,  8'd1},   {8'd23,  8'd2},   {8'd34,  8'd13},
    {8'd15,  8'd25},  {8'd6,   8'd106}, {8'd107, 8'd16},  {8'd106, 8'd3},
    {8'd136, 8'd126}, {8'd137, 8'd0},   {8'd8,   8'd0},   {8'd9,   8'd4},
    {8'd40,  8'd0},   {8'd200, 8'd0},   {8'd255, 8'd255}, {8'd1,   8'd7},
    {8'd1,   8'd30},  {8'd1,   8'd200}, {8'd1,   8'd9},   {8'd117, 8'd100},
    {8'd31,  8'd22},  {8'd7,   8'd11}
  };

  always #2 clk = ~clk;

  melody_note_decoder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  melody_note_decoder_checker note_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (failures),
    .notes_in_flight (notes_in_flight)
  );

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("** melody_note_decoder_core: FAILED **");
    $finish;
  end

  // result side: random back-pressure plus a long hold every few hundred results
  initial begin
    int unsigned results_taken;
    int unsigned next_choke;
    results_taken = 0;
    next_choke    = 700;
    out_ready     = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) results_taken++;
      if (rst_n && results_taken >= next_choke) begin
        next_choke += 500;
        out_ready <= 1'b0;
        repeat (CHOKE_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= rst_n && (rx_idle_pct == 0 || $urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one note, with a random idle gap first, and hold it until taken
  task automatic send_note(input mnd_in_t item);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every result is back and the pipe is empty
  task automatic drain_notes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (notes_in_flight != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] key, input logic [15:0] octave,
                              input logic [15:0] whole, input logic [15:0] sustain);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_SHIFT;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_index <= CFG_OCTAVE_SHIFT;
    cfg_wdata <= octave;
    @(posedge clk);
    cfg_index <= CFG_WHOLE_NOTE_MS;
    cfg_wdata <= whole;
    @(posedge clk);
    cfg_index <= CFG_SUSTAIN_FRACTION;
    cfg_wdata <= sustain;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed codes with random digits, the rest raw noise
  task automatic play_random_notes(input int unsigned count);
    int unsigned note, octave, sharp, expo, effect, dotted;
    mnd_in_t     item;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) begin
        note   = $urandom_range(7);
        octave = $urandom_range(3);
        sharp  = $urandom_range(1);
        expo   = $urandom_range(6);
        effect = $urandom_range(2);
        dotted = $urandom_range(1);
        item.tone_code   = 8'(sharp * 100 + octave * 10 + note);
        item.length_code = 8'(dotted * 100 + effect * 10 + expo);
      end else begin
        item.tone_code   = 8'($urandom);
        item.length_code = 8'($urandom);
      end
      send_note(item);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_KEY_SHIFT;
    cfg_wdata   = '0;
    tx_idle_pct = 7;
    rx_idle_pct = 85;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed notes under the reset register values
    foreach (opening_notes[i]) send_note(opening_notes[i]);

    // upper extremes, then lower extremes
    drain_notes();
    program_regs(16'd11, 16'(3'sd2), 16'd40000, 16'd256);
    play_random_notes(PHASE_NOTES);
    drain_notes();
    program_regs(16'd0, 16'(-3'sd2), 16'd1, 16'd0);
    play_random_notes(PHASE_NOTES);

    // out-of-range register values: wrap and saturation
    tx_idle_pct = 85;
    rx_idle_pct = 7;
    drain_notes();
    program_regs(16'd15, 16'(3'b100), 16'hFFFF, 16'd511);
    play_random_notes(PHASE_NOTES);
    drain_notes();
    program_regs(16'd12, 16'(3'b011), 16'd0, 16'd257);
    play_random_notes(PHASE_NOTES);
    drain_notes();
    program_regs(16'($urandom), {13'($urandom), 3'b101}, 16'($urandom), 16'($urandom));
    play_random_notes(PHASE_NOTES);

    // in-range random settings at full rate
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (2) begin
      drain_notes();
      program_regs(16'($urandom_range(11)), 16'(3'($urandom_range(4) - 2)),
                   16'($urandom_range(1, 40000)), 16'($urandom_range(256)));
      play_random_notes(PHASE_NOTES);
    end

    drain_notes();
    if (failures == 0) begin
      $display("** melody_note_decoder_core: PASSED **");
    end else begin
      $display("** melody_note_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
